/* rtl/b64dec_pkg.sv */
// Shared types and constants for the Base64 decoder.
package b64dec_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SYMBOL_62 = 2'd0,
        CFG_SYMBOL_63 = 2'd1
    } t_cfg_index;

    // Reset values of the symbol registers ('+' and '/')
    localparam logic [7:0] SYMBOL_62_RESET = 8'h2B;
    localparam logic [7:0] SYMBOL_63_RESET = 8'h2F;

    // Padding character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Input word: one encoded character
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_word;

    // Output word: one decoded byte and status
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       end_of_message;
    } t_out_word;

    // Sextet lookup result
    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_sextet;

endpackage

/* rtl/base64_decoder.sv */
// Streaming Base64 decoder: input register, decode logic and output register.
//
// Takes one character per cycle while the output is not stalled and returns a
// word whenever a byte becomes complete (on the second, third and fourth
// character of each group) or the character is marked last. Each character is
// held in the input register and its result word in the output register.
// Throughput is one character per cycle while the output is not stalled, set by
// the single decode stage between the two registers, which updates the group
// state for each character. Up to two trailing '=' are stripped, a lone leftover
// character is dropped, and a third '=', data after '=' or an unknown character
// raises decode_error until the end of the message. The characters for sextets
// 62 and 63 come from two configuration registers (index 0 and 1), which the
// user must write only while the block is empty; the block does not enforce it.
module base64_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input character channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  b64dec_pkg::t_in_word  i_in_data,
    // Output byte channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output b64dec_pkg::t_out_word o_out_data,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [b64dec_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    // Configuration registers
    logic [7:0] r_symbol_62;
    logic [7:0] r_symbol_63;

    // Input stage
    logic                 r_s1_vld;
    b64dec_pkg::t_in_word r_s1;

    // Decode state
    logic [1:0] r_pos,   n_pos;
    logic [5:0] r_carry, n_carry;
    logic [1:0] r_pads,  n_pads;
    logic       r_err,   n_err;

    // Output stage
    logic                  r_out_vld;
    b64dec_pkg::t_out_word r_out;
    b64dec_pkg::t_out_word n_out;

    logic                 s1_has_result;
    logic                 s1_go;
    logic                 out_free;
    logic                 in_take;
    b64dec_pkg::t_sextet  sx;

    // Map a character to its sextet value
    function automatic b64dec_pkg::t_sextet sextet_of(input logic [7:0] c,
                                                      input logic [7:0] s62,
                                                      input logic [7:0] s63);
        b64dec_pkg::t_sextet r;
        r.hit   = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c != b64dec_pkg::PAD_CHAR && c == s62) begin
            r.value = 6'd62;
        end else if (c != b64dec_pkg::PAD_CHAR && c == s63) begin
            r.value = 6'd63;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // Configuration writes; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_62 <= b64dec_pkg::SYMBOL_62_RESET;
            r_symbol_63 <= b64dec_pkg::SYMBOL_63_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                b64dec_pkg::CFG_SYMBOL_62: r_symbol_62 <= i_cfg_data;
                b64dec_pkg::CFG_SYMBOL_63: r_symbol_63 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode of the word held in the input stage
    assign sx = sextet_of(r_s1.char_in, r_symbol_62, r_symbol_63);

    always_comb begin
        n_pos   = r_pos;
        n_carry = r_carry;
        n_pads  = r_pads;
        n_err   = r_err;
        n_out   = '0;
        if (!r_err) begin
            if (r_s1.char_in == b64dec_pkg::PAD_CHAR) begin
                if (r_pads != 2'd2) begin
                    n_pads = r_pads + 2'd1;
                end else begin
                    n_err = 1'b1;
                end
            end else if (r_pads != 2'd0) begin
                // data after padding
                n_err = 1'b1;
            end else if (!sx.hit) begin
                n_err = 1'b1;
            end else begin
                case (r_pos)
                    2'd0: begin
                        n_carry = sx.value;
                    end
                    2'd1: begin
                        n_out.data_byte  = {r_carry, sx.value[5:4]};
                        n_carry          = {2'b00, sx.value[3:0]};
                        n_out.byte_valid = 1'b1;
                    end
                    2'd2: begin
                        n_out.data_byte  = {r_carry[3:0], sx.value[5:2]};
                        n_carry          = {4'b0000, sx.value[1:0]};
                        n_out.byte_valid = 1'b1;
                    end
                    default: begin
                        n_out.data_byte  = {r_carry[1:0], sx.value};
                        n_carry          = 6'd0;
                        n_out.byte_valid = 1'b1;
                    end
                endcase
                n_pos = r_pos + 2'd1;
            end
        end
        n_out.decode_error   = n_err;
        n_out.end_of_message = r_s1.last_char;
        // end of message clears all message state
        if (r_s1.last_char) begin
            n_pos   = 2'd0;
            n_carry = 6'd0;
            n_pads  = 2'd0;
            n_err   = 1'b0;
        end
    end

    // Stage flow control
    assign s1_has_result = n_out.byte_valid || r_s1.last_char;
    assign out_free      = !r_out_vld || !i_out_stall;
    assign s1_go         = r_s1_vld && (out_free || !s1_has_result);
    assign o_in_stall    = r_s1_vld && !s1_go;
    assign in_take       = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_take) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= i_in_data;
        end
    end

    // Decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_carry <= 6'd0;
            r_pads  <= 2'd0;
            r_err   <= 1'b0;
        end else if (s1_go) begin
            r_pos   <= n_pos;
            r_carry <= n_carry;
            r_pads  <= n_pads;
            r_err   <= n_err;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && s1_has_result) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A word without a byte is only sent for the last character
    a_result_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.byte_valid |-> r_out.end_of_message)
        else $error("result word with neither byte nor end of message");

    // Empty words carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.byte_valid |-> r_out.data_byte == 8'd0)
        else $error("non-zero data on a word without a byte");

    // No byte is produced once the message is in error
    a_no_byte_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.byte_valid |-> !r_out.decode_error)
        else $error("byte produced in error state");

    // State is clean after the last character has been decoded
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1.last_char |=>
            r_pos == 2'd0 && r_carry == 6'd0 && r_pads == 2'd0 && !r_err)
        else $error("message state not cleared after last character");

    // The input only stalls while the input stage holds a word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_vld && r_out_vld && i_out_stall)
        else $error("input stalled without a blocked word");

endmodule
